### rtl/tvr_pkg.sv
// Shared constants, codes and control types of the TARCH variance recursion block.
`default_nettype none

package tvr_pkg;

  // Lag depths and step counter width
  localparam int MAX_P       = 4;
  localparam int MAX_O       = 4;
  localparam int MAX_Q       = 4;
  localparam int COUNT_WIDTH = 16;

  // Coefficient table: omega, then alpha, gamma and beta lanes
  localparam int NTERM  = MAX_P + MAX_O + MAX_Q;
  localparam int NCOEF  = 1 + NTERM;
  localparam int COEF_W = $clog2(NCOEF);
  localparam int TERM_W = $clog2(NTERM);

  // Arithmetic widths: full product, rounded product, accumulator
  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int RND_W   = PROD_W - 16;
  localparam int ACC_W   = RND_W + $clog2(NCOEF) + 1;
  localparam int WARM_W  = 16;
  localparam int CMP_W   = (COUNT_WIDTH > WARM_W) ? COUNT_WIDTH : WARM_W;

  // Input item kinds
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_O    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_Q    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKCAST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_OUT = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              take_sample;
    logic              take_coef;
    logic              load_backcast;
    logic              acc_init;
    logic              mul_term;
    logic [TERM_W-1:0] term;
    logic              acc_add;
    logic              sat_ht;
    logic              mul_sq;
    logic              sat_sq;
    logic              finish;
  } tvr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic warm;
    logic square_en;
    logic out_free;
  } tvr_stat_t;

endpackage

`default_nettype wire

### rtl/tvr_ifs.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface tvr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        restart;
  logic [31:0] sample;
  logic [31:0] indicator_sample;
  logic [3:0]  coef_index;
  logic [31:0] coef_value;

  modport source (output valid, cmd, restart, sample, indicator_sample, coef_index,
                  coef_value, input ready);
  modport sink   (input valid, cmd, restart, sample, indicator_sample, coef_index,
                  coef_value, output ready);
endinterface

interface tvr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] variance;
  logic        saturated;

  modport source (output valid, variance, saturated, input ready);
  modport sink   (input valid, variance, saturated, output ready);
endinterface

`default_nettype wire

### rtl/tarch_variance_recursion_core.sv
// Top level of the TARCH/GJR conditional variance recursion block.
`default_nettype none

// Streams one time step per sample beat and returns one variance beat per
// sample; coefficient-load beats return nothing. A warm-up step goes from
// START to FINISH; a computed step runs MAC, DRAIN and SAT, then SQMUL and
// SQRND with output squaring, on one shared 32x32 multiplier that walks all
// twelve lag terms one per cycle (terms beyond the configured orders count as
// zero). One item is in flight at a time; the result register lets the next
// item be accepted while a result still waits, and a finished step holds until
// that register is free. Configuration writes are meant for idle periods only.
module tarch_variance_recursion_core
  import tvr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  tvr_in_if.sink                    in_ch,
  tvr_out_if.source                 out_ch
);

  tvr_cmd_t  cmd;
  tvr_stat_t stat;

  tvr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ch.ready)
  );

  tvr_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_restart          (in_ch.restart),
    .in_sample           (in_ch.sample),
    .in_indicator_sample (in_ch.indicator_sample),
    .in_coef_index       (in_ch.coef_index),
    .in_coef_value       (in_ch.coef_value),
    .cmd                 (cmd),
    .stat                (stat),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_variance        (out_ch.variance),
    .out_saturated       (out_ch.saturated)
  );

endmodule

`default_nettype wire

### rtl/tvr_ctrl.sv
// Sequencer that steps one item through warm-up, multiply-accumulate and squaring.
`default_nettype none

module tvr_ctrl
  import tvr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_cmd,
  input  wire tvr_stat_t stat,
  output tvr_cmd_t       cmd,
  output logic           in_ready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_MAC    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_SAT    = 3'd4;
  localparam logic [2:0] S_SQMUL  = 3'd5;
  localparam logic [2:0] S_SQRND  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(NTERM - 1);

  logic [2:0]        state, state_next;
  logic [TERM_W-1:0] term, term_next;

  // State and term counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    term_next  = term;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.term   = term;
    unique case (state)
      S_IDLE: begin
        // Ready is high here, so a valid beat is taken this cycle
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.take_coef = 1'b1;
          end else begin
            cmd.take_sample = 1'b1;
            state_next      = S_START;
          end
        end
      end
      S_START: begin
        if (stat.warm) begin
          cmd.load_backcast = 1'b1;
          state_next        = S_FINISH;
        end else begin
          cmd.acc_init = 1'b1;
          term_next    = '0;
          state_next   = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mul_term = 1'b1;
        cmd.acc_add  = (term != '0);
        if (term == TERM_LAST) begin
          state_next = S_DRAIN;
        end else begin
          term_next = term + TERM_W'(1);
        end
      end
      S_DRAIN: begin
        cmd.acc_add = 1'b1;
        state_next  = S_SAT;
      end
      S_SAT: begin
        cmd.sat_ht = 1'b1;
        state_next = stat.square_en ? S_SQMUL : S_FINISH;
      end
      S_SQMUL: begin
        cmd.mul_sq = 1'b1;
        state_next = S_SQRND;
      end
      S_SQRND: begin
        cmd.sat_sq = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/tvr_datapath.sv
// Coefficient table, lag histories, shared multiplier, accumulator and result register.
`default_nettype none

module tvr_datapath
  import tvr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata,
  input  wire logic                 in_restart,
  input  wire logic [DATA_W-1:0]    in_sample,
  input  wire logic [DATA_W-1:0]    in_indicator_sample,
  input  wire logic [3:0]           in_coef_index,
  input  wire logic [DATA_W-1:0]    in_coef_value,
  input  wire tvr_cmd_t             cmd,
  output tvr_stat_t                 stat,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [DATA_W-1:0]         out_variance,
  output logic                      out_saturated
);

  // Configuration registers
  logic [2:0]        order_p, order_o, order_q;
  logic [WARM_W-1:0] warmup_len;
  logic [DATA_W-1:0] backcast_value;
  logic              square_output;

  // Coefficients, histories, step count
  logic signed [DATA_W-1:0] coef_table [NCOEF];
  logic signed [DATA_W-1:0] sample_hist [MAX_P];
  logic signed [DATA_W-1:0] ind_hist [MAX_O];
  logic signed [DATA_W-1:0] var_hist [MAX_Q];
  logic [COUNT_WIDTH-1:0]   step_count;

  // Current item and arithmetic registers
  logic signed [DATA_W-1:0] smp, ind;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] ht, emit;
  logic                     sat_flag;

  // Term operand selection
  logic signed [DATA_W-1:0] hist_all [NTERM];
  logic                     term_en [NTERM];
  logic signed [DATA_W-1:0] coef_sel, hist_sel;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  prod_rnd_acc;

  function automatic logic is_ovf(input logic [ACC_W-1:0] v);
    return !((&v[ACC_W-1:DATA_W-1]) || (~|v[ACC_W-1:DATA_W-1]));
  endfunction

  function automatic logic [DATA_W-1:0] clip32(input logic [ACC_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (is_ovf(v)) begin
      r = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      order_p        <= 3'd1;
      order_o        <= 3'd1;
      order_q        <= 3'd1;
      warmup_len     <= WARM_W'(4);
      backcast_value <= DATA_W'(65536);
      square_output  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORDER_P:    order_p        <= cfg_wdata[2:0];
        REG_ORDER_O:    order_o        <= cfg_wdata[2:0];
        REG_ORDER_Q:    order_q        <= cfg_wdata[2:0];
        REG_WARMUP:     warmup_len     <= cfg_wdata[WARM_W-1:0];
        REG_BACKCAST:   backcast_value <= cfg_wdata;
        REG_SQUARE_OUT: square_output  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Coefficient loads; slots past the table are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCOEF; i++) coef_table[i] <= '0;
    end else if (cmd.take_coef && (int'(in_coef_index) < NCOEF)) begin
      coef_table[COEF_W'(in_coef_index)] <= in_coef_value;
    end
  end

  // Capture the step's sample and indicator
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      smp <= in_sample;
      ind <= in_indicator_sample;
    end
  end

  // Histories and step count: clear on restart, shift at the end of a step
  always_ff @(posedge clk) begin
    if (rst || (cmd.take_sample && in_restart)) begin
      for (int i = 0; i < MAX_P; i++) sample_hist[i] <= '0;
      for (int i = 0; i < MAX_O; i++) ind_hist[i] <= '0;
      for (int i = 0; i < MAX_Q; i++) var_hist[i] <= '0;
      step_count <= '0;
    end else if (cmd.finish) begin
      for (int i = MAX_P - 1; i > 0; i--) sample_hist[i] <= sample_hist[i-1];
      for (int i = MAX_O - 1; i > 0; i--) ind_hist[i] <= ind_hist[i-1];
      for (int i = MAX_Q - 1; i > 0; i--) var_hist[i] <= var_hist[i-1];
      sample_hist[0] <= smp;
      ind_hist[0]    <= ind;
      var_hist[0]    <= ht;
      if (step_count != '1) step_count <= step_count + COUNT_WIDTH'(1);
    end
  end

  // Flatten the three lag groups into one term list with enables
  always_comb begin
    for (int j = 0; j < MAX_P; j++) begin
      hist_all[j] = sample_hist[j];
      term_en[j]  = (j < int'(order_p));
    end
    for (int j = 0; j < MAX_O; j++) begin
      hist_all[MAX_P+j] = ind_hist[j];
      term_en[MAX_P+j]  = (j < int'(order_o));
    end
    for (int j = 0; j < MAX_Q; j++) begin
      hist_all[MAX_P+MAX_O+j] = var_hist[j];
      term_en[MAX_P+MAX_O+j]  = (j < int'(order_q));
    end
  end

  // Terms beyond the configured orders multiply by zero
  assign coef_sel     = coef_table[COEF_W'(cmd.term) + COEF_W'(1)];
  assign hist_sel     = term_en[cmd.term] ? hist_all[cmd.term] : '0;
  assign mul_a        = cmd.mul_sq ? ht : coef_sel;
  assign mul_b        = cmd.mul_sq ? ht : hist_sel;
  assign prod_rnd     = (prod + 64'sd32768) >>> 16;
  assign prod_rnd_acc = prod_rnd[ACC_W-1:0];

  // Shared multiplier
  always_ff @(posedge clk) begin
    if (cmd.mul_term || cmd.mul_sq) begin
      prod <= mul_a * mul_b;
    end
  end

  // Accumulator seeded with omega
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc <= ACC_W'(coef_table[0]);
    end else if (cmd.acc_add) begin
      acc <= acc + prod_rnd_acc;
    end
  end

  // Variance, emitted value and clip flag
  always_ff @(posedge clk) begin
    if (cmd.load_backcast) begin
      ht       <= backcast_value;
      emit     <= backcast_value;
      sat_flag <= 1'b0;
    end else if (cmd.sat_ht) begin
      ht       <= clip32(acc);
      emit     <= clip32(acc);
      sat_flag <= is_ovf(acc);
    end else if (cmd.sat_sq) begin
      emit     <= clip32(prod_rnd_acc);
      sat_flag <= sat_flag | is_ovf(prod_rnd_acc);
    end
  end

  // Result register: hold a beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_variance  <= emit;
      out_saturated <= sat_flag;
    end
  end

  assign stat.warm      = (CMP_W'(step_count) < CMP_W'(warmup_len));
  assign stat.square_en = square_output;
  assign stat.out_free  = !out_valid;

  // A result is only written into an empty output register
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid)
    else $error("result written over a pending beat");

  // A restart step starts counting from zero
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_sample && in_restart) |=> (step_count == '0))
    else $error("restart did not clear step count");

  // Squaring follows its own multiply
  a_sq_order: assert property (@(posedge clk) disable iff (rst)
    cmd.sat_sq |-> $past(cmd.mul_sq))
    else $error("square rounded without a square product");

endmodule

`default_nettype wire

### sim/tb_tarch_variance_recursion_core.sv
// Self-checking testbench for the TARCH variance recursion core: driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_tarch_variance_recursion_core
  import tvr_pkg::*;
();

  // Coefficient table slots
  localparam int SLOT_OMEGA = 0;
  localparam int SLOT_ALPHA = 1;
  localparam int SLOT_GAMMA = 1 + MAX_P;
  localparam int SLOT_BETA  = 1 + MAX_P + MAX_O;

  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic        cmd;
    logic        restart;
    logic [31:0] sample;
    logic [31:0] indicator_sample;
    logic [3:0]  coef_index;
    logic [31:0] coef_value;
  } step_item_t;

  typedef struct packed {
    logic [31:0] variance;
    logic        saturated;
  } variance_beat_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  tvr_in_if  step_bus ();
  tvr_out_if result_bus ();

  tarch_variance_recursion_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (step_bus),
    .out_ch    (result_bus)
  );

  // Predictor state: settings, coefficients, lag histories, step counter
  logic [2:0]               ord_p, ord_o, ord_q;
  logic [15:0]              warm_len;
  logic signed [31:0]       backcast;
  logic                     sq_out;
  logic signed [31:0]       coef_tab [NCOEF];
  logic signed [31:0]       smp_hist [MAX_P];
  logic signed [31:0]       ind_hist [MAX_O];
  logic signed [31:0]       var_hist [MAX_Q];
  logic [COUNT_WIDTH-1:0]   step_cnt;

  step_item_t     pending_steps [$];
  variance_beat_t variance_due [$];
  int unsigned    beats_queued = 0;
  int unsigned    beats_taken = 0;
  int unsigned    errors = 0;

  step_item_t     on_bus;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;
  int unsigned    stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [63:0] round_to_q16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  // Returns {clipped, value}
  function automatic logic [32:0] clip_to_32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // Mostly values within +/- spread, with extremes and full-range words mixed in
  function automatic logic [31:0] pick_q16(input int unsigned spread, input int unsigned wild);
    if ($urandom_range(0, 15) < wild) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        default: return $urandom();
      endcase
    end
    return $urandom_range(0, 2 * spread) - spread;
  endfunction

  function automatic step_item_t random_beat();
    step_item_t it;
    it.sample           = $urandom();
    it.indicator_sample = $urandom();
    it.coef_index       = $urandom_range(0, 15);
    it.coef_value       = $urandom();
    if ($urandom_range(0, 7) == 0) begin
      it.cmd        = CMD_LOAD;
      it.restart    = $urandom_range(0, 1);
      it.coef_value = pick_q16(32'h8000, 1);
    end else begin
      it.cmd              = CMD_SAMPLE;
      it.restart          = ($urandom_range(0, 24) == 0);
      it.sample           = pick_q16(32'h4_0000, 4);
      it.indicator_sample = pick_q16(32'h4_0000, 4);
    end
    return it;
  endfunction

  // Advance the predictor by one accepted beat and log the result it owes
  task automatic forecast_step(input step_item_t it);
    logic signed [63:0] acc, lhs, rhs;
    logic signed [31:0] ht, emit;
    logic [32:0]        clip;
    logic               sat;
    int                 n_alpha, n_gamma, n_beta;
    variance_beat_t     due;
    if (it.cmd == CMD_LOAD) begin
      if (it.coef_index < NCOEF) coef_tab[it.coef_index] = it.coef_value;
    end else begin
      if (it.restart) begin
        for (int i = 0; i < MAX_P; i++) smp_hist[i] = '0;
        for (int i = 0; i < MAX_O; i++) ind_hist[i] = '0;
        for (int i = 0; i < MAX_Q; i++) var_hist[i] = '0;
        step_cnt = '0;
      end
      sat = 1'b0;
      if (step_cnt < warm_len) begin
        ht   = backcast;
        emit = backcast;
      end else begin
        n_alpha = (ord_p > MAX_P) ? MAX_P : ord_p;
        n_gamma = (ord_o > MAX_O) ? MAX_O : ord_o;
        n_beta  = (ord_q > MAX_Q) ? MAX_Q : ord_q;
        acc = coef_tab[SLOT_OMEGA];
        for (int i = 0; i < n_alpha; i++) begin
          lhs = coef_tab[SLOT_ALPHA + i];
          rhs = smp_hist[i];
          acc += round_to_q16(lhs * rhs);
        end
        for (int i = 0; i < n_gamma; i++) begin
          lhs = coef_tab[SLOT_GAMMA + i];
          rhs = ind_hist[i];
          acc += round_to_q16(lhs * rhs);
        end
        for (int i = 0; i < n_beta; i++) begin
          lhs = coef_tab[SLOT_BETA + i];
          rhs = var_hist[i];
          acc += round_to_q16(lhs * rhs);
        end
        clip = clip_to_32(acc);
        sat  = clip[32];
        ht   = clip[31:0];
        emit = ht;
        // square the emitted value only; history keeps ht
        if (sq_out) begin
          lhs  = ht;
          clip = clip_to_32(round_to_q16(lhs * lhs));
          sat  = sat | clip[32];
          emit = clip[31:0];
        end
      end
      for (int i = MAX_P - 1; i > 0; i--) smp_hist[i] = smp_hist[i - 1];
      for (int i = MAX_O - 1; i > 0; i--) ind_hist[i] = ind_hist[i - 1];
      for (int i = MAX_Q - 1; i > 0; i--) var_hist[i] = var_hist[i - 1];
      smp_hist[0] = it.sample;
      ind_hist[0] = it.indicator_sample;
      var_hist[0] = ht;
      if (step_cnt != '1) step_cnt++;
      due.variance  = emit;
      due.saturated = sat;
      variance_due.push_back(due);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic queue_step(input logic restart, input logic [31:0] smp,
                            input logic [31:0] ind);
    step_item_t it;
    it = random_beat();
    it.cmd              = CMD_SAMPLE;
    it.restart          = restart;
    it.sample           = smp;
    it.indicator_sample = ind;
    pending_steps.push_back(it);
    beats_queued++;
  endtask

  task automatic queue_load(input logic restart, input logic [3:0] slot,
                            input logic [31:0] value);
    step_item_t it;
    it = random_beat();
    it.cmd        = CMD_LOAD;
    it.restart    = restart;
    it.coef_index = slot;
    it.coef_value = value;
    pending_steps.push_back(it);
    beats_queued++;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    case (idx)
      REG_ORDER_P:    ord_p = value[2:0];
      REG_ORDER_O:    ord_o = value[2:0];
      REG_ORDER_Q:    ord_q = value[2:0];
      REG_WARMUP:     warm_len = value[15:0];
      REG_BACKCAST:   backcast = value;
      REG_SQUARE_OUT: sq_out = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input logic [2:0] p, input logic [2:0] o, input logic [2:0] q,
                                input logic [15:0] warm, input logic [31:0] bc,
                                input logic sq);
    set_reg(REG_ORDER_P, 32'(p));
    set_reg(REG_ORDER_O, 32'(o));
    set_reg(REG_ORDER_Q, 32'(q));
    set_reg(REG_WARMUP, 32'(warm));
    set_reg(REG_BACKCAST, bc);
    set_reg(REG_SQUARE_OUT, 32'(sq));
  endtask

  // Wait until every beat is taken and every result is back, then let a load finish
  task automatic settle_block();
    while (beats_taken != beats_queued || variance_due.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // Input driver: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      step_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (step_bus.valid && step_bus.ready) begin
        forecast_step(on_bus);
        beats_taken++;
      end
      if (!step_bus.valid || step_bus.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          step_bus.valid <= 1'b0;
        end else if (pending_steps.size() != 0) begin
          on_bus = pending_steps.pop_front();
          step_bus.valid            <= 1'b1;
          step_bus.cmd              <= on_bus.cmd;
          step_bus.restart          <= on_bus.restart;
          step_bus.sample           <= on_bus.sample;
          step_bus.indicator_sample <= on_bus.indicator_sample;
          step_bus.coef_index       <= on_bus.coef_index;
          step_bus.coef_value       <= on_bus.coef_value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 20);
          end
        end else begin
          step_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each beat, stall on a pattern of runs
  always @(posedge clk) begin
    variance_beat_t due;
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (variance_due.size() == 0) begin
          report_mismatch("result with nothing expected", result_bus.variance, 'x);
        end else begin
          due = variance_due.pop_front();
          if (result_bus.variance !== due.variance)
            report_mismatch("variance", result_bus.variance, due.variance);
          if (result_bus.saturated !== due.saturated)
            report_mismatch("saturated", 32'(result_bus.saturated), 32'(due.saturated));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            result_bus.ready <= 1'b1;
            stall_left = 150;
          end
          1, 2, 3, 4, 5: begin
            result_bus.ready <= 1'b1;
            stall_left = $urandom_range(0, 8);
          end
          default: begin
            result_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 30);
          end
        endcase
      end
    end
  end

  initial begin
    step_item_t it;
    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_index                 = '0;
    cfg_wdata                 = '0;
    step_bus.valid            = 1'b0;
    step_bus.cmd              = CMD_SAMPLE;
    step_bus.restart          = 1'b0;
    step_bus.sample           = '0;
    step_bus.indicator_sample = '0;
    step_bus.coef_index       = '0;
    step_bus.coef_value       = '0;
    result_bus.ready          = 1'b0;
    ord_p    = 3'd1;
    ord_o    = 3'd1;
    ord_q    = 3'd1;
    warm_len = 16'd4;
    backcast = 32'sh0001_0000;
    sq_out   = 1'b0;
    for (int i = 0; i < NCOEF; i++) coef_tab[i] = '0;
    for (int i = 0; i < MAX_P; i++) smp_hist[i] = '0;
    for (int i = 0; i < MAX_O; i++) ind_hist[i] = '0;
    for (int i = 0; i < MAX_Q; i++) var_hist[i] = '0;
    step_cnt = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Settings after reset: extremes, loads with restart, slots past the table
    queue_step(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_step(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_load(1'b1, SLOT_OMEGA, 32'h7FFF_FFFF);
    queue_load(1'b0, SLOT_ALPHA, 32'h8000_0000);
    queue_load(1'b0, SLOT_GAMMA, 32'h7FFF_FFFF);
    queue_load(1'b0, SLOT_BETA, 32'h0001_0000);
    queue_load(1'b0, 4'hF, 32'hFFFF_FFFF);
    queue_load(1'b0, NCOEF, 32'h1234_5678);
    queue_step(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_step(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_step(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_step(1'b0, 32'h0000_0000, 32'h0000_0000);
    queue_load(1'b0, SLOT_OMEGA, 32'h8000_0000);
    queue_step(1'b0, 32'h0001_0000, 32'h8000_0000);
    queue_step(1'b1, 32'h0000_8000, 32'h0000_8000);
    settle_block();

    // Zero warm-up with squaring: first steps see cleared history, square clips
    apply_settings(3'd4, 3'd4, 3'd4, 16'd0, 32'h8000_0000, 1'b1);
    queue_load(1'b0, SLOT_OMEGA, 32'h0002_0000);
    for (int i = 0; i < MAX_P; i++) queue_load(1'b0, SLOT_ALPHA + i, 32'h0000_8000);
    queue_step(1'b1, 32'h0003_0000, 32'hFFFF_0000);
    queue_step(1'b0, 32'hFFFD_0000, 32'h0001_0000);
    queue_step(1'b0, 32'h0000_4000, 32'h0000_0001);
    queue_load(1'b0, SLOT_OMEGA, 32'h7FFF_FFFF);
    queue_step(1'b0, 32'h0000_0000, 32'h0000_0000);
    settle_block();

    // Random phases, each under its own settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_settings(3'd7, 3'd7, 3'd7, 16'd0, 32'h7FFF_FFFF, 1'b1);
        1: apply_settings(3'd0, 3'd0, 3'd0, 16'hFFFF, 32'h8000_0000, 1'b0);
        2: apply_settings(3'd4, 3'd4, 3'd4, 16'd4, 32'h0001_0000, 1'b0);
        default: apply_settings($urandom_range(0, 7), $urandom_range(0, 7),
                                $urandom_range(0, 7), $urandom_range(0, 6),
                                pick_q16(32'h2_0000, 4), $urandom_range(0, 1));
      endcase
      if (ph % 2 == 0)
        for (int s = 0; s < NCOEF; s++) queue_load(1'b0, s, pick_q16(32'h8000, 1));
      for (int n = 0; n < 200; n++) begin
        it = random_beat();
        pending_steps.push_back(it);
        beats_queued++;
      end
      settle_block();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
